### src/lcd_nibble_shift_writer_defines.svh
// Assertion macros for the LCD nibble shift writer.
`ifndef LCD_NIBBLE_SHIFT_WRITER_DEFINES_SVH
`define LCD_NIBBLE_SHIFT_WRITER_DEFINES_SVH
`ifndef SYNTHESIS
`define LNSW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LNSW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LNSW_ASSERT_NOW(label, ante, cons, msg)
`define LNSW_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### src/lnsw_pkg.sv
// Shared types, codes and constants of the LCD nibble shift writer.
package lnsw_pkg;

  localparam logic [2:0] CMD_DATA   = 3'd0;
  localparam logic [2:0] CMD_INSTR  = 3'd1;
  localparam logic [2:0] CMD_CURSOR = 3'd2;
  localparam logic [2:0] CMD_INIT   = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [1:0] CFG_SETTLE = 2'd0;
  localparam logic [1:0] CFG_PULSE  = 2'd1;

  localparam logic [15:0] SETTLE_RESET = 16'd20000;
  localparam int          COLUMNS      = 16;
  localparam int          QUEUE_DEPTH  = 4;

  localparam logic [7:0] BYTE_CLEAR = 8'h01;
  localparam logic [7:0] NIBBLE_MASK = 8'hF0;
  localparam logic [7:0] RS_BIT = 8'h08;
  localparam logic [7:0] EN_BIT = 8'h02;

  localparam logic [1:0] PH_HI_EN = 2'd0;
  localparam logic [1:0] PH_HI    = 2'd1;
  localparam logic [1:0] PH_LO_EN = 2'd2;
  localparam logic [1:0] PH_LO    = 2'd3;

  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
    logic       last;
  } lnsw_entry_t;

  typedef struct packed {
    logic       push;
    lnsw_entry_t entry;
  } lnsw_push_t;

  typedef struct packed {
    logic       busy;
    logic [1:0] init_idx;
  } lnsw_front_status_t;

  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = 8'h28;
      2'd1: b = 8'h0C;
      2'd2: b = 8'h06;
      2'd3: b = 8'h01;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

endpackage

### src/lcd_nibble_shift_writer.sv
// Top level of the LCD nibble shift writer: front end, byte queue and frame back end.
// A command is taken while the queue has room and no init is being queued; init queues four bytes.
// The back end emits one frame per cycle unless stalled or idle, four per byte and sixteen for init.
// The first frame of a command passes the byte queue and the output register before the outputs.
// Synchronous active-low reset empties the queue and output and sets the settle delay to 20000.
// Writes to the pulse width register are taken and have no effect on the frames.
`include "lcd_nibble_shift_writer_defines.svh"
module lcd_nibble_shift_writer #(
  parameter int QUEUE_DEPTH = lnsw_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_byte_value,
  input  logic        in_row,
  input  logic [3:0]  in_column,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_frame,
  output logic [15:0] out_wait_after_us,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0]                  settle_r;
  lnsw_pkg::lnsw_push_t         push;
  lnsw_pkg::lnsw_front_status_t front_status;
  lnsw_pkg::lnsw_entry_t        head;
  logic                         q_full, head_valid, pop;
  logic                         init_xfer, init_started;

  assign cfg_ready = 1'b1;

  assign init_xfer    = in_valid && !in_stall && in_command == lnsw_pkg::CMD_INIT;
  assign init_started = front_status.busy && front_status.init_idx == 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= lnsw_pkg::SETTLE_RESET;
    end else if (cfg_valid && cfg_ready && cfg_index == lnsw_pkg::CFG_SETTLE) begin
      settle_r <= cfg_data;
    end
  end

  lnsw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_byte_value(in_byte_value),
    .in_row       (in_row),
    .in_column    (in_column),
    .q_full       (q_full),
    .push_o       (push),
    .status_o     (front_status)
  );

  lnsw_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (push),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  lnsw_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .settle_delay     (settle_r),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame        (out_frame),
    .out_wait_after_us(out_wait_after_us),
    .out_last         (out_last)
  );

  `LNSW_ASSERT_NOW(a_push_not_full, push.push, !q_full, "byte pushed into a full queue")
  `LNSW_ASSERT_NOW(a_pop_has_head, pop, head_valid, "byte popped from an empty queue")
  `LNSW_ASSERT_NEXT(a_init_starts, init_xfer, init_started, "init transfer did not start")
  `LNSW_ASSERT_NOW(a_last_enable_low, out_valid && out_last, !out_frame[1], "last frame enabled")

endmodule

### src/lnsw_front.sv
// Front end: accepts commands and turns them into display bytes for the queue.
module lnsw_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_command,
  input  logic [7:0]                  in_byte_value,
  input  logic                        in_row,
  input  logic [3:0]                  in_column,
  input  logic                        q_full,
  output lnsw_pkg::lnsw_push_t        push_o,
  output lnsw_pkg::lnsw_front_status_t status_o
);

  localparam logic [6:0] COL_MAX = 7'(lnsw_pkg::COLUMNS - 1);

  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       accept;
  logic [3:0] col_sat;

  assign in_stall = busy_r | q_full;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    if ({3'b000, in_column} > COL_MAX) begin
      col_sat = COL_MAX[3:0];
    end else begin
      col_sat = in_column;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    push_o   = '0;
    if (busy_r) begin
      if (!q_full) begin
        push_o.push          = 1'b1;
        push_o.entry.value   = lnsw_pkg::init_byte(idx_r);
        push_o.entry.is_data = 1'b0;
        push_o.entry.last    = (idx_r == 2'd3);
        if (idx_r == 2'd3) begin
          busy_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
    end else if (accept) begin
      push_o.entry.last = 1'b1;
      case (in_command)
        lnsw_pkg::CMD_DATA: begin
          push_o.push          = 1'b1;
          push_o.entry.value   = in_byte_value;
          push_o.entry.is_data = 1'b1;
        end
        lnsw_pkg::CMD_INSTR: begin
          push_o.push        = 1'b1;
          push_o.entry.value = in_byte_value;
        end
        lnsw_pkg::CMD_CURSOR: begin
          push_o.push        = 1'b1;
          push_o.entry.value = {1'b1, in_row, 2'b00, col_sat};
        end
        lnsw_pkg::CMD_INIT: begin
          push_o.push        = 1'b1;
          push_o.entry.value = lnsw_pkg::init_byte(2'd0);
          push_o.entry.last  = 1'b0;
          busy_nxt           = 1'b1;
          idx_nxt            = 2'd1;
        end
        lnsw_pkg::CMD_CLEAR: begin
          push_o.push        = 1'b1;
          push_o.entry.value = lnsw_pkg::BYTE_CLEAR;
        end
        default: begin
          push_o.push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign status_o.busy     = busy_r;
  assign status_o.init_idx = idx_r;

endmodule

### src/lnsw_queue.sv
// Small byte queue between the front end and the frame back end.
module lnsw_queue #(
  parameter int DEPTH = lnsw_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lnsw_pkg::lnsw_push_t  push_i,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output lnsw_pkg::lnsw_entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  lnsw_pkg::lnsw_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push_i.push & ~full;
  assign do_pop     = pop & head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_i.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

### src/lnsw_back.sv
// Back end: expands each queued byte into four frames behind an output register.
module lnsw_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [15:0]           settle_delay,
  input  logic                  head_valid,
  input  lnsw_pkg::lnsw_entry_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_frame,
  output logic [15:0]           out_wait_after_us,
  output logic                  out_last
);

  logic        out_valid_r;
  logic [7:0]  frame_r, frame_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic        last_r, last_nxt;
  logic [1:0]  phase_r;
  logic        advance, emit;
  logic [7:0]  rs, hi, lo;

  assign advance = ~out_valid_r | ~out_stall;
  assign emit    = advance & head_valid;
  assign pop     = emit & (phase_r == lnsw_pkg::PH_LO);

  assign rs = head.is_data ? lnsw_pkg::RS_BIT : 8'h00;
  assign hi = (head.value & lnsw_pkg::NIBBLE_MASK) | rs;
  assign lo = ({head.value[3:0], 4'h0} & lnsw_pkg::NIBBLE_MASK) | rs;

  always_comb begin
    last_nxt = 1'b0;
    case (phase_r)
      lnsw_pkg::PH_HI_EN: begin
        frame_nxt = hi | lnsw_pkg::EN_BIT;
        wait_nxt  = settle_delay;
      end
      lnsw_pkg::PH_HI: begin
        frame_nxt = hi;
        wait_nxt  = 16'd0;
      end
      lnsw_pkg::PH_LO_EN: begin
        frame_nxt = lo | lnsw_pkg::EN_BIT;
        wait_nxt  = settle_delay;
      end
      lnsw_pkg::PH_LO: begin
        frame_nxt = lo;
        wait_nxt  = settle_delay;
        last_nxt  = head.last;
      end
      default: begin
        frame_nxt = hi;
        wait_nxt  = settle_delay;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= lnsw_pkg::PH_HI_EN;
    end else begin
      if (advance) begin
        out_valid_r <= head_valid;
      end
      if (emit) begin
        phase_r <= phase_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      frame_r <= frame_nxt;
      wait_r  <= wait_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame         = frame_r;
  assign out_wait_after_us = wait_r;
  assign out_last          = last_r;

endmodule

### tb/lcd_nibble_shift_writer_tb.sv
// Self-checking testbench for the LCD nibble shift writer: predicted frames versus the result stream.
module lcd_nibble_shift_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int ITEMS_PER_PHASE = 90;
  localparam logic [2:0] CMD_TOP = 3'd7;
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;
  localparam logic [7:0] ROW0_BASE = 8'd128;
  localparam logic [7:0] ROW1_BASE = 8'd192;
  localparam logic [7:0] INIT_SEQ [4] = '{8'h28, 8'h0C, 8'h06, 8'h01};

  typedef struct packed {
    logic [7:0]  frame;
    logic [15:0] wait_us;
    logic        last;
  } lcd_frame_t;

  class frame_tracker;
    lcd_frame_t pending_frames[$];
    logic [15:0] settle_us;
    logic [7:0] pulse_us;
    int errors;

    function new();
      settle_us = lnsw_pkg::SETTLE_RESET;
      pulse_us = 8'd1;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [15:0] value);
      if (index == lnsw_pkg::CFG_SETTLE) begin
        settle_us = value;
      end else if (index == lnsw_pkg::CFG_PULSE) begin
        pulse_us = value[7:0];
      end
    endfunction

    function void add_byte(logic [7:0] b, logic is_data, logic final_byte);
      logic [7:0] rs;
      logic [7:0] hi;
      logic [7:0] lo;
      rs = is_data ? lnsw_pkg::RS_BIT : 8'h00;
      hi = (b & lnsw_pkg::NIBBLE_MASK) | rs | lnsw_pkg::EN_BIT;
      lo = {b[3:0], 4'h0} | rs | lnsw_pkg::EN_BIT;
      pending_frames.push_back(lcd_frame_t'{hi, settle_us, 1'b0});
      pending_frames.push_back(lcd_frame_t'{hi & ~lnsw_pkg::EN_BIT, 16'd0, 1'b0});
      pending_frames.push_back(lcd_frame_t'{lo, settle_us, 1'b0});
      pending_frames.push_back(lcd_frame_t'{lo & ~lnsw_pkg::EN_BIT, settle_us, final_byte});
    endfunction

    function void note_command(logic [2:0] cmd, logic [7:0] b, logic row, logic [3:0] col);
      logic [7:0] col_sat;
      col_sat = (col > lnsw_pkg::COLUMNS - 1) ? 8'(lnsw_pkg::COLUMNS - 1) : {4'h0, col};
      case (cmd)
        lnsw_pkg::CMD_DATA: add_byte(b, 1'b1, 1'b1);
        lnsw_pkg::CMD_INSTR: add_byte(b, 1'b0, 1'b1);
        lnsw_pkg::CMD_CURSOR: add_byte((row ? ROW1_BASE : ROW0_BASE) + col_sat, 1'b0, 1'b1);
        lnsw_pkg::CMD_INIT: begin
          for (int i = 0; i < 4; i++) add_byte(INIT_SEQ[i], 1'b0, i == 3);
        end
        lnsw_pkg::CMD_CLEAR: add_byte(lnsw_pkg::BYTE_CLEAR, 1'b0, 1'b1);
        default: ;
      endcase
    endfunction

    function void check_frame(logic [7:0] frame, logic [15:0] wait_us, logic last);
      lcd_frame_t exp_f;
      if (pending_frames.size() == 0) begin
        $error("unexpected frame %h (wait %0d, last %0d)", frame, wait_us, last);
        errors++;
        return;
      end
      exp_f = pending_frames.pop_front();
      if (frame !== exp_f.frame) begin
        $error("frame: expected %h, got %h", exp_f.frame, frame);
        errors++;
      end
      if (wait_us !== exp_f.wait_us) begin
        $error("wait_after_us: expected %0d, got %0d", exp_f.wait_us, wait_us);
        errors++;
      end
      if (last !== exp_f.last) begin
        $error("last: expected %0d, got %0d", exp_f.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_frames.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_command = '0;
  logic [7:0]  in_byte_value = '0;
  logic        in_row = 1'b0;
  logic [3:0]  in_column = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_frame;
  logic [15:0] out_wait_after_us;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  frame_tracker frames = new();
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int cycle_count = 0;

  lcd_nibble_shift_writer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_byte_value(in_byte_value),
    .in_row(in_row),
    .in_column(in_column),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_frame(out_frame),
    .out_wait_after_us(out_wait_after_us),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lcd_nibble_shift_writer_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      frames.check_frame(out_frame, out_wait_after_us, out_last);
    end
  end

  task automatic send_command(logic [2:0] cmd, logic [7:0] b, logic row, logic [3:0] col);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      in_byte_value <= 8'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_byte_value <= b;
    in_row <= row;
    in_column <= col;
    do @(posedge clk); while (in_stall);
    frames.note_command(cmd, b, row, col);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (frames.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] index, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    frames.write_reg(index, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_commands(int count);
    int taken;
    logic [2:0] cmd;
    taken = 0;
    while (taken < count) begin
      if ($urandom_range(99) < 5) begin
        cmd = 3'($urandom_range(CMD_TOP, lnsw_pkg::CMD_CLEAR + 1));
      end else begin
        cmd = 3'($urandom_range(lnsw_pkg::CMD_CLEAR, lnsw_pkg::CMD_DATA));
        taken++;
      end
      send_command(cmd, 8'($urandom), 1'($urandom), 4'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_command(lnsw_pkg::CMD_DATA, 8'h00, 1'b0, 4'h0);
    send_command(lnsw_pkg::CMD_DATA, 8'hFF, 1'b1, 4'hF);
    send_command(lnsw_pkg::CMD_DATA, 8'hA5, 1'b0, 4'h0);
    send_command(lnsw_pkg::CMD_INSTR, 8'h00, 1'b0, 4'h0);
    send_command(lnsw_pkg::CMD_INSTR, 8'hFF, 1'b0, 4'h0);
    send_command(lnsw_pkg::CMD_INSTR, 8'h5A, 1'b1, 4'hA);
    send_command(lnsw_pkg::CMD_CURSOR, 8'h00, 1'b0, 4'h0);
    send_command(lnsw_pkg::CMD_CURSOR, 8'hFF, 1'b1, 4'hF);
    send_command(lnsw_pkg::CMD_CURSOR, 8'h00, 1'b0, 4'hF);
    send_command(lnsw_pkg::CMD_CURSOR, 8'h00, 1'b1, 4'h0);
    send_command(lnsw_pkg::CMD_INIT, 8'h00, 1'b0, 4'h0);
    send_command(lnsw_pkg::CMD_CLEAR, 8'hFF, 1'b1, 4'hF);
    for (int c = lnsw_pkg::CMD_CLEAR + 1; c <= CMD_TOP; c++) begin
      send_command(3'(c), 8'($urandom), 1'($urandom), 4'($urandom));
    end
    send_command(lnsw_pkg::CMD_DATA, 8'h3C, 1'b0, 4'h0);
    drain();

    write_cfg(lnsw_pkg::CFG_SETTLE, 16'd0);
    write_cfg(lnsw_pkg::CFG_PULSE, 16'd255);
    random_commands(ITEMS_PER_PHASE);
    drain();

    write_cfg(lnsw_pkg::CFG_SETTLE, 16'hFFFF);
    write_cfg(lnsw_pkg::CFG_PULSE, 16'd1);
    in_idle_pct = 53;
    random_commands(ITEMS_PER_PHASE);
    drain();

    write_cfg(lnsw_pkg::CFG_SETTLE, 16'($urandom));
    write_cfg(lnsw_pkg::CFG_PULSE, 16'($urandom_range(255, 1)));
    write_cfg(CFG_SPARE_A, 16'($urandom));
    in_idle_pct = 0;
    out_stall_pct = 53;
    random_commands(ITEMS_PER_PHASE);
    drain();

    write_cfg(lnsw_pkg::CFG_SETTLE, 16'($urandom));
    write_cfg(CFG_SPARE_B, 16'($urandom));
    in_idle_pct = 32;
    out_stall_pct = 32;
    random_commands(ITEMS_PER_PHASE);
    drain();

    if (frames.errors == 0) begin
      $display("lcd_nibble_shift_writer_tb: clean");
    end else begin
      $display("lcd_nibble_shift_writer_tb: errors");
    end
    $finish;
  end

endmodule
